FILE: src/poa_pkg.sv
`timescale 1ns / 1ps

package poa_pkg;

  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned TEMP_W  = 16;
  localparam int unsigned SUM_W   = 32;
  localparam int unsigned CNT_W   = 17;
  localparam int unsigned MODE_W  = 2;

  localparam int unsigned MAX_COUNT = 65536;

  // Quotient magnitude never exceeds 2^15, so only the low half of the dividend is iterated
  localparam int unsigned QUO_W     = 16;
  localparam int unsigned DIV_CNT_W = 5;

  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 88;

  localparam logic [MODE_W-1:0] MODE_YEARLY  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MONTHLY = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DAILY   = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV_INIT,
    ST_DIV,
    ST_LOAD
  } state_e;

  typedef struct packed {
    logic latch_in;
    logic accumulate;
    logic start;
    logic div_start;
    logic load_out;
    logic load_final;
    logic clear_end;
  } poa_cmd_t;

  typedef struct packed {
    logic in_ok;
    logic in_last;
    logic open;
    logic match;
    logic div_done;
    logic out_free;
  } poa_sts_t;

endpackage

FILE: src/poa_ctrl.sv
`timescale 1ns / 1ps

module poa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  poa_pkg::poa_sts_t sts_i,
  output poa_pkg::poa_cmd_t cmd_o
);
  import poa_pkg::*;

  state_e state_q, state_d;
  logic   final_q, final_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      final_q <= 1'b0;
    end else begin
      state_q <= state_d;
      final_q <= final_d;
    end
  end

  always_comb begin
    state_d = state_q;
    final_d = final_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        state_d = ST_IDLE;
        if (sts_i.in_ok) begin
          if (!sts_i.match && sts_i.open) begin
            state_d = ST_DIV_INIT;
            final_d = 1'b0;
          end else if (sts_i.in_last) begin
            state_d = ST_DIV_INIT;
            final_d = 1'b1;
          end
        end else if (sts_i.in_last && sts_i.open) begin
          state_d = ST_DIV_INIT;
          final_d = 1'b1;
        end
      end
      ST_DIV_INIT: begin
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (sts_i.div_done) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (sts_i.out_free) begin
          if (!final_q && sts_i.in_last) begin
            state_d = ST_DIV_INIT;
            final_d = 1'b1;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o     = 1'b1;
        cmd_o.latch_in = in_valid_i;
      end
      ST_EVAL: begin
        if (sts_i.in_ok) begin
          cmd_o.accumulate = sts_i.match;
          cmd_o.start      = !sts_i.open;
        end else if (sts_i.in_last && !sts_i.open) begin
          cmd_o.clear_end = 1'b1;
        end
      end
      ST_DIV_INIT: begin
        cmd_o.div_start = 1'b1;
      end
      ST_DIV: begin
      end
      ST_LOAD: begin
        if (sts_i.out_free) begin
          cmd_o.load_out   = 1'b1;
          cmd_o.load_final = final_q;
          cmd_o.start      = !final_q;
          cmd_o.clear_end  = final_q;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: src/poa_datapath.sv
`timescale 1ns / 1ps

module poa_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [poa_pkg::MODE_W-1:0]          cfg_wdata_i,
  input  logic [poa_pkg::IN_DATA_W-1:0]       in_data_i,
  input  logic                                in_ok_i,
  input  logic                                in_last_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic [poa_pkg::OUT_DATA_W-1:0]      out_data_o,
  output logic                                out_last_o,
  input  poa_pkg::poa_cmd_t                   cmd_i,
  output poa_pkg::poa_sts_t                   sts_o
);
  import poa_pkg::*;

  logic [MODE_W-1:0] mode_q;

  logic [YEAR_W-1:0]         in_year_q;
  logic [MONTH_W-1:0]        in_month_q;
  logic [DAY_W-1:0]          in_day_q;
  logic signed [TEMP_W-1:0]  in_temp_q;
  logic                      in_ok_q;
  logic                      in_last_q;

  logic [YEAR_W-1:0]         per_year_q;
  logic [MONTH_W-1:0]        per_month_q;
  logic [DAY_W-1:0]          per_day_q;
  logic                      open_q;
  logic signed [SUM_W-1:0]   sum_q;
  logic [CNT_W-1:0]          cnt_q;
  logic signed [TEMP_W-1:0]  high_q;
  logic signed [TEMP_W-1:0]  low_q;
  logic signed [TEMP_W-1:0]  prior_q;
  logic                      has_prior_q;

  logic [CNT_W-1:0]          rem_q, rem_d;
  logic [QUO_W-1:0]          dvd_q;
  logic [QUO_W-1:0]          quo_q;
  logic                      neg_q;
  logic [DIV_CNT_W-1:0]      step_q;

  logic                      out_valid_q;
  logic [OUT_DATA_W-1:0]     out_data_q;
  logic                      out_last_q;

  logic [MONTH_W-1:0]        key_month;
  logic [DAY_W-1:0]          key_day;
  logic signed [SUM_W-1:0]   temp_ext;
  logic [SUM_W-1:0]          sum_mag;
  logic [CNT_W+1:0]          trial;
  logic                      qbit;
  logic signed [TEMP_W-1:0]  avg;
  logic signed [TEMP_W-1:0]  open_val;

  always_comb begin
    key_month = MONTH_W'(1);
    key_day   = DAY_W'(1);
    case (mode_q)
      MODE_MONTHLY: key_month = in_month_q;
      MODE_DAILY: begin
        key_month = in_month_q;
        key_day   = in_day_q;
      end
      default: begin
      end
    endcase
  end

  assign temp_ext = SUM_W'(in_temp_q);
  assign sum_mag  = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);

  assign trial = {1'b0, rem_q, dvd_q[QUO_W-1]} - {2'b00, cnt_q};
  assign qbit  = !trial[CNT_W+1];
  assign rem_d = qbit ? trial[CNT_W-1:0] : {rem_q[CNT_W-2:0], dvd_q[QUO_W-1]};

  assign avg      = neg_q ? TEMP_W'(-quo_q) : TEMP_W'(quo_q);
  assign open_val = has_prior_q ? prior_q : avg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_YEARLY;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      in_year_q  <= in_data_i[13:0];
      in_month_q <= in_data_i[17:14];
      in_day_q   <= in_data_i[22:18];
      in_temp_q  <= in_data_i[38:23];
      in_ok_q    <= in_ok_i;
      in_last_q  <= in_last_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q      <= 1'b0;
      sum_q       <= '0;
      cnt_q       <= '0;
      per_year_q  <= '0;
      per_month_q <= '0;
      per_day_q   <= '0;
      high_q      <= '0;
      low_q       <= '0;
      prior_q     <= '0;
      has_prior_q <= 1'b0;
    end else begin
      if (cmd_i.accumulate) begin
        if (cnt_q < CNT_W'(MAX_COUNT)) begin
          sum_q <= sum_q + temp_ext;
          cnt_q <= cnt_q + CNT_W'(1);
        end
        if (in_temp_q > high_q) high_q <= in_temp_q;
        if (in_temp_q < low_q) low_q <= in_temp_q;
      end
      if (cmd_i.start) begin
        per_year_q  <= in_year_q;
        per_month_q <= key_month;
        per_day_q   <= key_day;
        open_q      <= 1'b1;
        sum_q       <= temp_ext;
        cnt_q       <= CNT_W'(1);
        high_q      <= in_temp_q;
        low_q       <= in_temp_q;
      end
      if (cmd_i.clear_end) begin
        open_q      <= 1'b0;
        sum_q       <= '0;
        cnt_q       <= '0;
        prior_q     <= '0;
        has_prior_q <= 1'b0;
      end else if (cmd_i.load_out) begin
        prior_q     <= avg;
        has_prior_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (cmd_i.div_start) begin
      step_q <= DIV_CNT_W'(QUO_W);
    end else if (step_q != '0) begin
      step_q <= step_q - DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      neg_q <= sum_q[SUM_W-1];
      rem_q <= {1'b0, sum_mag[SUM_W-1:QUO_W]};
      dvd_q <= sum_mag[QUO_W-1:0];
      quo_q <= '0;
    end else if (step_q != '0) begin
      rem_q <= rem_d;
      dvd_q <= {dvd_q[QUO_W-2:0], 1'b0};
      quo_q <= {quo_q[QUO_W-2:0], qbit};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_data_q <= {1'b0, low_q, high_q, avg, open_val, per_day_q, per_month_q, per_year_q};
      out_last_q <= cmd_i.load_final;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_last_o  = out_last_q;

  assign sts_o.in_ok    = in_ok_q;
  assign sts_o.in_last  = in_last_q;
  assign sts_o.open     = open_q;
  assign sts_o.match    = open_q && (per_year_q == in_year_q) && (per_month_q == key_month)
                          && (per_day_q == key_day);
  assign sts_o.div_done = (step_q == '0);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

endmodule

FILE: src/period_ohlc_aggregator.sv
`timescale 1ns / 1ps
// Candlestick aggregator for date-sorted temperature samples.
// Input stream (s_axis): one sample per request; tlast marks the final record of a run and
// tuser carries the date-valid flag. Samples with the flag low are dropped, though their
// tlast still flushes the open period.
// Output stream (m_axis): one candle per finished period; tlast marks the final candle.
// cfg_we_i/cfg_wdata_i write the grouping mode (0 yearly, 1 monthly, 2 daily, 3 as yearly);
// write it only while the block is idle.
// A sample that closes no period is latched, evaluated and dropped back to idle. Each candle
// runs the 16-step restoring divider that forms the period average, one quotient bit per
// cycle. A sample that closes a period and ends the stream yields two candles.
// The candle sits in an output register: the block takes the next sample while it waits,
// and stalls only when a new candle is ready and the previous one is still not taken.
// Reset: asynchronous, active low; clears the mode to yearly and closes any open period.
module period_ohlc_aggregator (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [poa_pkg::MODE_W-1:0]         cfg_wdata_i,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // sample_year[13:0], sample_month[17:14], sample_day[22:18], temperature[38:23], zero[39]
  input  logic [poa_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // date_ok
  input  logic                               s_axis_tuser,
  input  logic                               s_axis_tlast,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // label_year[13:0], label_month[17:14], label_day[22:18], open_value[38:23],
  // close_value[54:39], high_value[70:55], low_value[86:71], zero[87]
  output logic [poa_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  output logic                               m_axis_tlast
);
  import poa_pkg::*;

  poa_cmd_t cmd;
  poa_sts_t sts;

  poa_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  poa_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_data_i  (s_axis_tdata),
    .in_ok_i    (s_axis_tuser),
    .in_last_i  (s_axis_tlast),
    .out_ready_i(m_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_data_o (m_axis_tdata),
    .out_last_o (m_axis_tlast),
    .cmd_i      (cmd),
    .sts_o      (sts)
  );

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> (!m_axis_tvalid || m_axis_tready))
    else $error("candle loaded over an untaken candle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request accepted while previous one still in work");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_start |-> sts.div_done)
    else $error("divider restarted while busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> sts.open)
    else $error("candle emitted with no open period");
`endif

endmodule

FILE: verif/tb_period_ohlc_aggregator.sv
`timescale 1ns / 1ps

module tb_period_ohlc_aggregator;
  import poa_pkg::*;

  localparam logic [MODE_W-1:0] MODE_ALIAS_YEARLY = 2'd3;
  localparam int unsigned SETTLE_CYCLES = 48;
  localparam int unsigned HOLD_CYCLES = 600;
  localparam int unsigned RANDOM_PHASE_ITEMS = 250;

  typedef enum int {
    RX_FREE,
    RX_COIN,
    RX_SPARSE
  } rx_style_e;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [TEMP_W-1:0]  open_v;
    logic [TEMP_W-1:0]  close_v;
    logic [TEMP_W-1:0]  high_v;
    logic [TEMP_W-1:0]  low_v;
    logic               last_candle;
  } candle_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [MODE_W-1:0]     cfg_wdata_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  // sample_year[13:0], sample_month[17:14], sample_day[22:18], temperature[38:23], zero[39]
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  // date_ok
  logic                  s_axis_tuser;
  logic                  s_axis_tlast;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  // label_year[13:0], label_month[17:14], label_day[22:18], open_value[38:23],
  // close_value[54:39], high_value[70:55], low_value[86:71], zero[87]
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;

  // candle predictor state
  logic [MODE_W-1:0]        grp_mode;
  logic [YEAR_W-1:0]        cur_year;
  logic [MONTH_W-1:0]       cur_month;
  logic [DAY_W-1:0]         cur_day;
  bit                       cur_live;
  logic signed [SUM_W-1:0]  sum_acc;
  logic [CNT_W-1:0]         cnt_acc;
  logic signed [TEMP_W-1:0] hi_acc;
  logic signed [TEMP_W-1:0] lo_acc;
  logic signed [TEMP_W-1:0] prev_close;
  bit                       prev_valid;
  candle_t                  pending_candles[$];

  int fail_count = 0;
  int samples_taken = 0;
  int candles_seen = 0;
  bit pacing_on = 1'b1;
  int burst_left = 0;
  bit hold_req = 1'b0;

  period_ohlc_aggregator u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic void close_candle(input bit last_one);
    longint  mean;
    candle_t c;
    mean = 0;
    if (cnt_acc != 0) mean = longint'(sum_acc) / longint'(cnt_acc);
    c.year        = cur_year;
    c.month       = cur_month;
    c.day         = cur_day;
    c.close_v     = mean[TEMP_W-1:0];
    c.open_v      = prev_valid ? prev_close : mean[TEMP_W-1:0];
    c.high_v      = hi_acc;
    c.low_v       = lo_acc;
    c.last_candle = last_one;
    pending_candles.push_back(c);
    prev_close = mean[TEMP_W-1:0];
    prev_valid = 1'b1;
  endfunction

  function automatic void fold_sample(input logic [YEAR_W-1:0] yr,
                                      input logic [MONTH_W-1:0] mo,
                                      input logic [DAY_W-1:0] dy, input bit ok,
                                      input logic signed [TEMP_W-1:0] tmp, input bit last);
    logic [MONTH_W-1:0] key_m;
    logic [DAY_W-1:0]   key_d;
    key_m = (grp_mode == MODE_MONTHLY || grp_mode == MODE_DAILY) ? mo : MONTH_W'(1);
    key_d = (grp_mode == MODE_DAILY) ? dy : DAY_W'(1);
    if (ok) begin
      if (cur_live && cur_year == yr && cur_month == key_m && cur_day == key_d) begin
        if (cnt_acc < MAX_COUNT) begin
          sum_acc = sum_acc + tmp;
          cnt_acc = cnt_acc + 1'b1;
        end
        if (tmp > hi_acc) hi_acc = tmp;
        if (tmp < lo_acc) lo_acc = tmp;
      end else begin
        if (cur_live) close_candle(1'b0);
        cur_year  = yr;
        cur_month = key_m;
        cur_day   = key_d;
        cur_live  = 1'b1;
        sum_acc   = tmp;
        cnt_acc   = 1;
        hi_acc    = tmp;
        lo_acc    = tmp;
      end
    end
    if (last) begin
      if (cur_live) close_candle(1'b1);
      cur_live   = 1'b0;
      sum_acc    = 0;
      cnt_acc    = 0;
      prev_valid = 1'b0;
      prev_close = 0;
    end
  endfunction

  function automatic void compare_field(input string what, input int want, input int got);
    if (want != got) begin
      fail_count++;
      $display("%0t: %s expected %0d got %0d", $time, what, want, got);
    end
  endfunction

  always @(posedge clk_i) begin : candle_check
    candle_t got;
    candle_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.year        = m_axis_tdata[13:0];
      got.month       = m_axis_tdata[17:14];
      got.day         = m_axis_tdata[22:18];
      got.open_v      = m_axis_tdata[38:23];
      got.close_v     = m_axis_tdata[54:39];
      got.high_v      = m_axis_tdata[70:55];
      got.low_v       = m_axis_tdata[86:71];
      got.last_candle = m_axis_tlast;
      candles_seen++;
      if (pending_candles.size() == 0) begin
        fail_count++;
        $display("%0t: candle expected none got tdata %h tlast %b", $time, m_axis_tdata,
                 m_axis_tlast);
      end else begin
        want = pending_candles.pop_front();
        compare_field("label_year", int'(want.year), int'(got.year));
        compare_field("label_month", int'(want.month), int'(got.month));
        compare_field("label_day", int'(want.day), int'(got.day));
        compare_field("open_value", int'($signed(want.open_v)), int'($signed(got.open_v)));
        compare_field("close_value", int'($signed(want.close_v)), int'($signed(got.close_v)));
        compare_field("high_value", int'($signed(want.high_v)), int'($signed(got.high_v)));
        compare_field("low_value", int'($signed(want.low_v)), int'($signed(got.low_v)));
        compare_field("final_candle", int'(want.last_candle), int'(got.last_candle));
      end
    end
  end

  // output side: change stall style now and then, hold off on request
  initial begin : rx_pattern
    rx_style_e style;
    int        phase;
    style = RX_FREE;
    phase = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        for (int i = 1; i < HOLD_CYCLES; i++) @(posedge clk_i);
      end else begin
        if (phase == 0) begin
          style = rx_style_e'($urandom_range(0, 2));
          phase = $urandom_range(16, 96);
        end
        phase--;
        case (style)
          RX_FREE: m_axis_tready <= 1'b1;
          RX_COIN: m_axis_tready <= 1'($urandom_range(0, 1));
          default: m_axis_tready <= (phase % 8) < 3;
        endcase
      end
    end
  end

  task automatic pace_sender();
    int gap;
    if (!pacing_on) return;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(0, 24);
    gap = $urandom_range(1, 10);
    s_axis_tvalid <= 1'b0;
    repeat (gap) @(posedge clk_i);
  endtask

  task automatic offer_sample(input int yr, input int mo, input int dy, input bit ok,
                              input int tmp, input bit last);
    logic [YEAR_W-1:0]        y;
    logic [MONTH_W-1:0]       m;
    logic [DAY_W-1:0]         d;
    logic signed [TEMP_W-1:0] t;
    y = yr[YEAR_W-1:0];
    m = mo[MONTH_W-1:0];
    d = dy[DAY_W-1:0];
    t = tmp[TEMP_W-1:0];
    s_axis_tdata  <= {1'b0, t, d, m, y};
    s_axis_tuser  <= ok;
    s_axis_tlast  <= last;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    fold_sample(y, m, d, ok, t, last);
    samples_taken++;
    pace_sender();
  endtask

  task automatic wait_for_drain();
    while (pending_candles.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_period_mode(input logic [MODE_W-1:0] mode);
    s_axis_tvalid <= 1'b0;
    wait_for_drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= mode;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    grp_mode = mode;
  endtask

  task automatic test_yearly_edges();
    offer_sample(0, 1, 1, 1'b0, 0, 1'b1);
    offer_sample(0, 1, 1, 1'b1, -32768, 1'b0);
    offer_sample(0, 12, 31, 1'b1, 32767, 1'b0);
    offer_sample(5, 3, 3, 1'b0, 123, 1'b0);
    offer_sample(9999, 15, 0, 1'b1, -3, 1'b0);
    offer_sample(16383, 0, 31, 1'b1, 100, 1'b1);
    offer_sample(16383, 0, 31, 1'b0, 0, 1'b1);
    offer_sample(5, 1, 1, 1'b1, 7, 1'b0);
    offer_sample(6, 1, 1, 1'b1, -7, 1'b0);
    offer_sample(5, 1, 1, 1'b1, -8, 1'b0);
    offer_sample(5, 1, 1, 1'b1, -1, 1'b0);
    offer_sample(5, 2, 2, 1'b0, 9, 1'b1);
  endtask

  task automatic test_grouping_modes();
    write_period_mode(MODE_ALIAS_YEARLY);
    offer_sample(2001, 1, 1, 1'b1, 10, 1'b0);
    offer_sample(2001, 7, 20, 1'b1, 20, 1'b0);
    offer_sample(2001, 15, 31, 1'b1, -30, 1'b0);
    offer_sample(2002, 1, 1, 1'b1, 0, 1'b1);
    write_period_mode(MODE_MONTHLY);
    offer_sample(2010, 4, 1, 1'b1, 5, 1'b0);
    offer_sample(2010, 4, 30, 1'b1, -5, 1'b0);
    offer_sample(2010, 5, 1, 1'b1, 1000, 1'b1);
    write_period_mode(MODE_DAILY);
    offer_sample(2010, 5, 1, 1'b1, -11, 1'b0);
    offer_sample(2010, 5, 1, 1'b1, -2, 1'b0);
    offer_sample(2010, 5, 2, 1'b1, 4, 1'b1);
  endtask

  task automatic test_mode_change_mid_period();
    offer_sample(2020, 3, 4, 1'b1, 10, 1'b0);
    write_period_mode(MODE_MONTHLY);
    offer_sample(2020, 3, 9, 1'b1, 20, 1'b0);
    write_period_mode(MODE_YEARLY);
    offer_sample(2020, 5, 5, 1'b1, 30, 1'b0);
    offer_sample(2020, 5, 5, 1'b1, -40, 1'b1);
  endtask

  task automatic test_output_backpressure();
    write_period_mode(MODE_DAILY);
    pacing_on = 1'b0;
    hold_req = 1'b1;
    for (int i = 0; i < 40; i++) offer_sample(2024, 1 + i / 28, 1 + i % 28, 1'b1,
                                              $urandom_range(0, 65535), i == 39);
    pacing_on = 1'b1;
  endtask

  task automatic random_phase(input int target);
    int done, pick, yr, mo, dy, tmp, base;
    bit ok, last;
    done = 0;
    yr = $urandom_range(1900, 2100);
    mo = 1;
    dy = 1;
    base = int'($urandom_range(0, 4000)) - 2000;
    while (done < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
      end else if (pick < 72) begin
        dy++;
        if (dy > 31) begin
          dy = 1;
          mo++;
        end
        if (mo > 12) begin
          mo = 1;
          yr++;
        end
      end else if (pick < 84) begin
        mo++;
        dy = $urandom_range(1, 31);
        if (mo > 12) begin
          mo = 1;
          yr++;
        end
      end else if (pick < 91) begin
        yr++;
        mo = $urandom_range(1, 12);
      end else if (pick < 96) begin
        yr = $urandom_range(0, 16383);
        mo = $urandom_range(0, 15);
        dy = $urandom_range(0, 31);
      end else begin
        yr--;
      end
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        tmp = int'($urandom_range(0, 65535)) - 32768;
      end else if (pick < 12) begin
        tmp = pick[0] ? 32767 : -32768;
      end else begin
        base = base + int'($urandom_range(0, 60)) - 30;
        tmp = base + int'($urandom_range(0, 600)) - 300;
      end
      ok = $urandom_range(0, 99) >= 6;
      last = $urandom_range(0, 99) < 3;
      offer_sample(yr, mo, dy, ok, tmp, last);
      if (ok || last) done++;
    end
  endtask

  task automatic test_random_streams();
    logic [MODE_W-1:0] modes[6];
    modes = '{MODE_DAILY, MODE_MONTHLY, MODE_YEARLY, MODE_ALIAS_YEARLY, MODE_DAILY,
              MODE_MONTHLY};
    foreach (modes[i]) begin
      write_period_mode(modes[i]);
      random_phase(RANDOM_PHASE_ITEMS);
    end
    offer_sample(0, 1, 1, 1'b0, 0, 1'b1);
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = MODE_YEARLY;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    s_axis_tlast  = 1'b0;
    grp_mode      = MODE_YEARLY;
    cur_year      = '0;
    cur_month     = '0;
    cur_day       = '0;
    cur_live      = 1'b0;
    sum_acc       = '0;
    cnt_acc       = '0;
    hi_acc        = '0;
    lo_acc        = '0;
    prev_close    = '0;
    prev_valid    = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_yearly_edges();
    test_grouping_modes();
    test_mode_change_mid_period();
    test_output_backpressure();
    test_random_streams();
    s_axis_tvalid <= 1'b0;
    wait_for_drain();
    $display("Covered %0d samples and %0d candles across yearly, monthly, daily and alias",
             samples_taken, candles_seen);
    $display("grouping, with invalid dates, mid-period mode changes and a long output stall.");
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("%0t: timeout with %0d candles still pending", $time, pending_candles.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
